// File: src/bst_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the bounding sphere transform block
// no dependencies

package bst_pkg;

   localparam logic       OP_WRITE_COLUMN = 1'b0;
   localparam logic       OP_SET_SPHERE   = 1'b1;
   localparam logic [1:0] COL_TRANSLATION = 2'd3;
   localparam logic [1:0] SPH_RADIUS      = 2'd3;

   localparam logic [1:0] LAST_ROW        = 2'd2;
   localparam logic [2:0] CENTER_LAST_SUB = 3'd5;
   localparam logic [2:0] NORM_LAST_SUB   = 3'd4;
   localparam logic [4:0] ROOT_LAST_STEP  = 5'd31;

   typedef struct packed {
      logic               operation;
      logic [15:0]        instance_index;
      logic [1:0]         column;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic signed [31:0] value_c;
      logic signed [31:0] value_d;
   } bst_req_type;

   typedef struct packed {
      logic [15:0]        result_index;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] world_radius;
   } bst_rsp_type;

   typedef enum logic [1:0] {
      MUL_CENTER = 2'd0,
      MUL_SQUARE = 2'd1,
      MUL_RADIUS = 2'd2
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [2:0] {
      NRM_HOLD  = 3'd0,
      NRM_LOAD  = 3'd1,
      NRM_ADD   = 3'd2,
      NRM_FIRST = 3'd3,
      NRM_BEST  = 3'd4
   } nrm_op_type;

   typedef struct packed {
      logic        load;
      mul_sel_type mul_sel;
      logic [1:0]  row;
      logic [1:0]  col;
      acc_op_type  acc_op;
      nrm_op_type  nrm_op;
      logic        center_wr;
      logic        root_init;
      logic        root_step;
      logic        radius_wr;
      logic        publish;
   } bst_cmd_type;

   typedef struct packed {
      logic out_free;
   } bst_status_type;

endpackage

// File: src/bst_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for request and response items
// depends on bst_pkg

interface bst_req_if import bst_pkg::*; ();
   logic        valid;
   logic        ready;
   bst_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bst_rsp_if import bst_pkg::*; ();
   logic        valid;
   logic        ready;
   bst_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: src/bst_ctrl.sv
`timescale 1ns / 1ps
// sequencer of the bounding sphere transform: steps the datapath through
// center sums, column norms, square root, radius and publish; depends on bst_pkg

module bst_ctrl import bst_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_operation,
   input  logic [1:0]     req_column,
   output logic           req_ready,
   input  bst_status_type status,
   output bst_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_CENTER  = 7'b0000010,
      ST_NORM    = 7'b0000100,
      ST_SETUP   = 7'b0001000,
      ST_ROOT    = 7'b0010000,
      ST_RADIUS  = 7'b0100000,
      ST_PUBLISH = 7'b1000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] row_ff, row_in;
   logic [2:0] sub_ff, sub_in;
   logic [4:0] iter_ff, iter_in;

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      sub_in    = sub_ff;
      iter_in   = iter_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_operation == OP_SET_SPHERE || req_column == COL_TRANSLATION) begin
                  state_in = ST_CENTER;
                  row_in   = 2'd0;
                  sub_in   = 3'd0;
               end
            end
         end
         ST_CENTER: begin
            // products of columns 0..3, translation taken times one
            cmd.mul_sel = MUL_CENTER;
            cmd.row     = row_ff;
            cmd.col     = sub_ff[1:0];
            case (sub_ff)
               3'd1:    cmd.acc_op = ACC_LOAD;
               3'd2:    cmd.acc_op = ACC_ADD;
               3'd3:    cmd.acc_op = ACC_ADD;
               3'd4:    cmd.acc_op = ACC_ADD;
               3'd5:    cmd.center_wr = 1'b1;
               default: cmd.acc_op = ACC_HOLD;
            endcase
            if (sub_ff == CENTER_LAST_SUB) begin
               sub_in = 3'd0;
               if (row_ff == LAST_ROW) begin
                  row_in   = 2'd0;
                  state_in = ST_NORM;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
         ST_NORM: begin
            cmd.mul_sel = MUL_SQUARE;
            cmd.col     = row_ff;
            cmd.row     = sub_ff[1:0];
            case (sub_ff)
               3'd1:    cmd.nrm_op = NRM_LOAD;
               3'd2:    cmd.nrm_op = NRM_ADD;
               3'd3:    cmd.nrm_op = NRM_ADD;
               3'd4:    cmd.nrm_op = (row_ff == 2'd0) ? NRM_FIRST : NRM_BEST;
               default: cmd.nrm_op = NRM_HOLD;
            endcase
            if (sub_ff == NORM_LAST_SUB) begin
               sub_in = 3'd0;
               if (row_ff == LAST_ROW) begin
                  row_in   = 2'd0;
                  state_in = ST_SETUP;
               end else begin
                  row_in = row_ff + 2'd1;
               end
            end else begin
               sub_in = sub_ff + 3'd1;
            end
         end
         ST_SETUP: begin
            cmd.root_init = 1'b1;
            iter_in       = 5'd0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (iter_ff == ROOT_LAST_STEP) begin
               sub_in   = 3'd0;
               state_in = ST_RADIUS;
            end else begin
               iter_in = iter_ff + 5'd1;
            end
         end
         ST_RADIUS: begin
            cmd.mul_sel = MUL_RADIUS;
            cmd.col     = SPH_RADIUS;
            if (sub_ff == 3'd0) begin
               sub_in = 3'd1;
            end else begin
               cmd.radius_wr = 1'b1;
               state_in      = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= 2'd0;
         sub_ff   <= 3'd0;
         iter_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         sub_ff   <= sub_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

// File: src/bst_dp.sv
`timescale 1ns / 1ps
// datapath of the bounding sphere transform: matrix and sphere stores, shared
// multiplier, accumulators, square root unit and output register; depends on bst_pkg

module bst_dp import bst_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bst_req_type      req_data,
   input  bst_cmd_type      cmd,
   output bst_status_type   status,
   bst_rsp_if.source        rsp
);

   localparam logic signed [63:0] SAT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SAT64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [31:0] SAT32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SAT32_MIN = 32'sh8000_0000;
   localparam logic signed [32:0] ONE_Q16   = 33'sd65536;
   localparam logic [63:0]        ROOT_BIT0 = 64'h4000_0000_0000_0000;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [63:0] s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63])
         sat_add64 = a[63] ? SAT64_MIN : SAT64_MAX;
      else
         sat_add64 = s;
   endfunction

   // floor shift by 16, then clamp to 32 bits
   function automatic logic signed [31:0] shift_sat32(input logic signed [63:0] x);
      logic signed [63:0] sh;
      sh = x >>> 16;
      if (sh[63:31] == {33{sh[63]}})
         shift_sat32 = sh[31:0];
      else
         shift_sat32 = sh[63] ? SAT32_MIN : SAT32_MAX;
   endfunction

   logic signed [31:0] mat_ff [12];
   logic signed [31:0] mat_in [12];
   logic signed [31:0] sph_ff [4];
   logic signed [31:0] sph_in [4];
   logic signed [31:0] center_ff [3];
   logic signed [31:0] center_in [3];

   logic [15:0]        tag_ff, tag_in;
   logic signed [65:0] prod_ff, prod_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [63:0]        nacc_ff, nacc_in;
   logic [63:0]        best_ff, best_in;
   logic [63:0]        rop_ff, rop_in;
   logic [63:0]        res_ff, res_in;
   logic [63:0]        bit_ff, bit_in;
   logic signed [31:0] radius_ff, radius_in;
   logic               out_valid_ff, out_valid_in;
   bst_rsp_type        out_data_ff, out_data_in;

   logic [3:0]         wr_base;
   logic [3:0]         rd_index;
   logic signed [31:0] mat_rd;
   logic signed [31:0] sph_rd;
   logic signed [32:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [63:0] prod64;
   logic [63:0]        trial;

   assign wr_base  = {1'b0, req_data.column, 1'b0} + {2'b00, req_data.column};
   assign rd_index = {1'b0, cmd.col, 1'b0} + {2'b00, cmd.col} + {2'b00, cmd.row};
   assign mat_rd   = mat_ff[rd_index];
   assign sph_rd   = sph_ff[cmd.col];
   assign prod64   = prod_ff[63:0];
   assign trial    = res_ff + bit_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_CENTER: begin
            mul_a = {mat_rd[31], mat_rd};
            mul_b = (cmd.col == COL_TRANSLATION) ? ONE_Q16 : {sph_rd[31], sph_rd};
         end
         MUL_SQUARE: begin
            mul_a = {mat_rd[31], mat_rd};
            mul_b = {mat_rd[31], mat_rd};
         end
         MUL_RADIUS: begin
            mul_a = {sph_rd[31], sph_rd};
            mul_b = {1'b0, res_ff[31:0]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_comb begin
      mat_in    = mat_ff;
      sph_in    = sph_ff;
      tag_in    = tag_ff;
      if (cmd.load) begin
         tag_in = req_data.instance_index;
         if (req_data.operation == OP_WRITE_COLUMN) begin
            mat_in[wr_base]        = req_data.value_a;
            mat_in[wr_base + 4'd1] = req_data.value_b;
            mat_in[wr_base + 4'd2] = req_data.value_c;
         end else begin
            sph_in[0] = req_data.value_a;
            sph_in[1] = req_data.value_b;
            sph_in[2] = req_data.value_c;
            sph_in[3] = req_data.value_d;
         end
      end
   end

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod64;
         ACC_ADD:  acc_in = sat_add64(acc_ff, prod64);
         default:  acc_in = acc_ff;
      endcase

      nacc_in = nacc_ff;
      best_in = best_ff;
      case (cmd.nrm_op)
         NRM_LOAD:  nacc_in = prod_ff[63:0];
         NRM_ADD:   nacc_in = nacc_ff + prod_ff[63:0];
         NRM_FIRST: best_in = nacc_ff;
         NRM_BEST:  best_in = (nacc_ff > best_ff) ? nacc_ff : best_ff;
         default:   nacc_in = nacc_ff;
      endcase

      center_in = center_ff;
      if (cmd.center_wr)
         center_in[cmd.row] = shift_sat32(acc_ff);

      radius_in = cmd.radius_wr ? shift_sat32(prod64) : radius_ff;
   end

   // one result bit per step, two operand bits consumed
   always_comb begin
      rop_in = rop_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (cmd.root_init) begin
         rop_in = best_ff;
         res_in = '0;
         bit_in = ROOT_BIT0;
      end else if (cmd.root_step) begin
         if (rop_ff >= trial) begin
            rop_in = rop_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_comb begin
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (cmd.publish) begin
         out_valid_in              = 1'b1;
         out_data_in.result_index  = tag_ff;
         out_data_in.center_x      = center_ff[0];
         out_data_in.center_y      = center_ff[1];
         out_data_in.center_z      = center_ff[2];
         out_data_in.world_radius  = radius_ff;
      end
   end

   assign status.out_free = !out_valid_ff || rsp.ready;
   assign rsp.valid       = out_valid_ff;
   assign rsp.payload     = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 12; i++) mat_ff[i] <= '0;
         for (int i = 0; i < 4; i++) sph_ff[i] <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mat_ff       <= mat_in;
         sph_ff       <= sph_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff      <= tag_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      nacc_ff     <= nacc_in;
      best_ff     <= best_in;
      rop_ff      <= rop_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      center_ff   <= center_in;
      radius_ff   <= radius_in;
      out_data_ff <= out_data_in;
   end

endmodule

// File: src/bounding_sphere_transform_top.sv
`timescale 1ns / 1ps
// Bounding sphere transform. Request items on req_chan either write one
// column of the affine world matrix (operation 0) or set the local sphere
// (operation 1). Writing column 3, or setting the sphere, starts a
// recompute and yields one response item on rsp_chan with the world center
// and radius, tagged with the request's instance index.
// A basis column write yields nothing and leaves req_chan.ready high. A
// recompute keeps req_chan.ready low during the three center sums and
// the three column norms, both through the one shared 33x33 multiplier,
// the square root setup and steps (one result bit a cycle), the radius
// product and the load of the output register. The response is valid in
// the cycle after that load; no new request is taken during a recompute.
// A finished response waits in the output register while a new request is
// taken; a second result only stalls the sequencer if rsp_chan.ready stays
// low. Reset clears the matrix, the sphere and any pending response.
// Depends on bst_pkg, bst_if, bst_ctrl and bst_dp.

module bounding_sphere_transform_top import bst_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bst_req_if.sink   req_chan,
   bst_rsp_if.source rsp_chan
);

   bst_cmd_type    cmd;
   bst_status_type status;
   logic           ready;

   assign req_chan.ready = ready;

   bst_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.payload.operation),
      .req_column    (req_chan.payload.column),
      .req_ready     (ready),
      .status        (status),
      .cmd           (cmd)
   );

   bst_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_chan.payload),
      .cmd      (cmd),
      .status   (status),
      .rsp      (rsp_chan)
   );

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> status.out_free)
      else $error("result published over a pending response");

   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_chan.valid)
      else $error("published result not shown on the response channel");

   a_load_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_chan.valid && req_chan.ready))
      else $error("store loaded without an accepted item");

   a_basis_quick: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready
       && req_chan.payload.operation == OP_WRITE_COLUMN
       && req_chan.payload.column != COL_TRANSLATION) |=> req_chan.ready)
      else $error("basis column write did not return to idle");

endmodule

// File: bench/tb_bounding_sphere_transform_top.sv
`timescale 1ns / 1ps
// self-checking bench for bounding_sphere_transform_top: clocked driver and monitor
// around a bit-exact world sphere predictor, with random idling and a long output hold-off
// depends on bst_pkg, bst_if and the bounding sphere transform rtl

module tb_bounding_sphere_transform_top;
   import bst_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int QUIET_TAIL    = 200;
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLD_AFTER    = 400;
   localparam int HOLD_CYCLES   = 500;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic signed [95:0] MAX32 = 96'sd2147483647;
   localparam logic signed [95:0] MIN32 = -96'sd2147483648;
   localparam logic signed [95:0] MAX64 = 96'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [95:0] MIN64 = -96'sh7FFF_FFFF_FFFF_FFFF - 96'sd1;

   localparam logic [31:0] Q_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN  = 32'h8000_0000;
   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam logic [31:0] Q_ZERO = 32'h0000_0000;

   logic clock;
   logic reset;

   bst_req_if req_chan ();
   bst_rsp_if rsp_chan ();

   bounding_sphere_transform_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state
   logic signed [31:0] world_matrix [12];
   logic signed [31:0] local_sphere [4];

   bst_req_type pending_reqs [$];
   bst_rsp_type sphere_due [$];

   int total_items;
   int items_issued;
   int items_taken;
   int spheres_checked;
   int column_writes;
   int sphere_sets;
   int mismatch_count;
   int error_count;
   int cycle_count;
   int send_gap;
   int rsp_stall;
   bit sender_calm;
   bit receiver_calm;
   bit hold_off;
   bit req_fired;

   function automatic logic [31:0] clamp32(input logic signed [95:0] x);
      if (x > MAX32) return Q_MAX;
      if (x < MIN32) return Q_MIN;
      return x[31:0];
   endfunction

   function automatic logic signed [95:0] add_sat64(input logic signed [95:0] a,
                                                    input logic signed [95:0] b);
      logic signed [95:0] sum;
      sum = a + b;
      if (sum > MAX64) return MAX64;
      if (sum < MIN64) return MIN64;
      return sum;
   endfunction

   function automatic logic [63:0] floor_root64(input logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = value;
      root  = '0;
      probe = 64'h1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // updates the model state; returns 1 when the item yields a world sphere
   function automatic bit predict_world_sphere(input bst_req_type rq, output bst_rsp_type ws);
      int base;
      logic signed [95:0] acc;
      logic signed [95:0] mv;
      logic signed [95:0] sv;
      logic signed [95:0] prod;
      logic [63:0] norm;
      logic [63:0] best;
      logic [63:0] scale;
      logic [31:0] centers [3];
      ws = '0;
      if (rq.operation == OP_WRITE_COLUMN) begin
         base = int'(rq.column) * 3;
         world_matrix[base]     = rq.value_a;
         world_matrix[base + 1] = rq.value_b;
         world_matrix[base + 2] = rq.value_c;
         if (rq.column != COL_TRANSLATION) return 1'b0;
      end else begin
         local_sphere[0] = rq.value_a;
         local_sphere[1] = rq.value_b;
         local_sphere[2] = rq.value_c;
         local_sphere[3] = rq.value_d;
      end
      for (int r = 0; r < 3; r++) begin
         acc = '0;
         for (int c = 0; c < 3; c++) begin
            mv  = world_matrix[c * 3 + r];
            sv  = local_sphere[c];
            acc = add_sat64(acc, mv * sv);
         end
         mv  = world_matrix[9 + r];
         acc = add_sat64(acc, mv <<< 16);
         centers[r] = clamp32(acc >>> 16);
      end
      best = '0;
      for (int c = 0; c < 3; c++) begin
         norm = '0;
         for (int r = 0; r < 3; r++) begin
            mv   = world_matrix[c * 3 + r];
            prod = mv * mv;
            norm = norm + prod[63:0];
         end
         if (norm > best) best = norm;
      end
      scale = floor_root64(best);
      sv    = local_sphere[3];
      mv    = $signed({32'd0, scale});
      ws.result_index = rq.instance_index;
      ws.center_x     = centers[0];
      ws.center_y     = centers[1];
      ws.center_z     = centers[2];
      ws.world_radius = clamp32((sv * mv) >>> 16);
      return 1'b1;
   endfunction

   function automatic logic [31:0] rand_q32();
      int v;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            v = int'($urandom_range(0, 524288)) - 262144;
            return v;
         end
         2: begin
            case ($urandom_range(0, 5))
               0: return Q_MAX;
               1: return Q_MIN;
               2: return Q_ZERO;
               3: return 32'hFFFF_FFFF;
               4: return 32'h0000_0001;
               default: return Q_ONE;
            endcase
         end
         3: begin
            v = int'($urandom_range(0, 16384)) - 8192;
            return ($urandom_range(0, 1) != 0) ? Q_ONE + v : -(Q_ONE + v);
         end
         default: begin
            v = int'($urandom_range(0, 200 << 16)) - (100 << 16);
            return v;
         end
      endcase
   endfunction

   function automatic bst_req_type make_item(input logic op, input logic [15:0] tag,
                                             input logic [1:0] col, input logic [31:0] a,
                                             input logic [31:0] b, input logic [31:0] c,
                                             input logic [31:0] d);
      bst_req_type rq;
      rq.operation      = op;
      rq.instance_index = tag;
      rq.column         = col;
      rq.value_a        = a;
      rq.value_b        = b;
      rq.value_c        = c;
      rq.value_d        = d;
      return rq;
   endfunction

   task automatic push_column(input logic [1:0] col);
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'($urandom), col, rand_q32(),
                                       rand_q32(), rand_q32(), $urandom));
   endtask

   task automatic push_sphere();
      pending_reqs.push_back(make_item(OP_SET_SPHERE, 16'($urandom), 2'($urandom), rand_q32(),
                                       rand_q32(), rand_q32(), rand_q32()));
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         error_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch %s: expected %h, got %h", label, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // item driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_fired) begin
         if (send_gap > 0) begin
            send_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_chan.payload <= pending_reqs.pop_front();
            req_chan.valid   <= 1'b1;
            items_issued++;
            if (items_issued % 50 == 0) sender_calm = ($urandom_range(0, 2) == 0);
            if (!sender_calm && items_issued < total_items - QUIET_TAIL
                && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 6);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off || rsp_stall > 0) begin
         if (rsp_stall > 0) rsp_stall--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (cycle_count % 256 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
         if (!receiver_calm && items_taken < total_items - QUIET_TAIL
             && $urandom_range(0, 3) == 0)
            rsp_stall = $urandom_range(1, 6);
      end
   end

   // monitor: predicts on each accepted request, checks each accepted result
   always @(posedge clock) begin
      bst_rsp_type ws;
      bst_rsp_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            items_taken++;
            if (req_chan.payload.operation == OP_WRITE_COLUMN) column_writes++;
            else sphere_sets++;
            if (predict_world_sphere(req_chan.payload, ws)) sphere_due.push_back(ws);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (sphere_due.size() == 0) begin
               error_count++;
               $display("unexpected result item, index %h", rsp_chan.payload.result_index);
            end else begin
               want = sphere_due.pop_front();
               spheres_checked++;
               check_field("result_index", 32'(want.result_index),
                           32'(rsp_chan.payload.result_index));
               check_field("center_x", want.center_x, rsp_chan.payload.center_x);
               check_field("center_y", want.center_y, rsp_chan.payload.center_y);
               check_field("center_z", want.center_z, rsp_chan.payload.center_z);
               check_field("world_radius", want.world_radius, rsp_chan.payload.world_radius);
            end
         end
      end
   end

   // long output hold-off so the block fills and stalls its input
   initial begin
      hold_off = 1'b0;
      while (items_taken < HOLD_AFTER) @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      int kind;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      world_matrix     = '{default: '0};
      local_sphere     = '{default: '0};
      items_issued     = 0;
      items_taken      = 0;
      spheres_checked  = 0;
      column_writes    = 0;
      sphere_sets      = 0;
      mismatch_count   = 0;
      error_count      = 0;
      cycle_count      = 0;
      send_gap         = 0;
      rsp_stall        = 0;
      sender_calm      = 1'b0;
      receiver_calm    = 1'b0;
      req_fired        = 1'b0;

      // zero matrix: center and radius come out zero
      pending_reqs.push_back(make_item(OP_SET_SPHERE, 16'h0000, 2'd3, Q_ONE, 32'h0002_0000,
                                       32'h0003_0000, 32'h0005_0000));
      // identity with translation
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h0001, 2'd0, Q_ONE, Q_ZERO, Q_ZERO,
                                       32'hDEAD_BEEF));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h0002, 2'd1, Q_ZERO, Q_ONE, Q_ZERO,
                                       Q_MAX));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h0003, 2'd2, Q_ZERO, Q_ZERO, Q_ONE,
                                       Q_MIN));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'hFFFF, COL_TRANSLATION,
                                       32'h000A_0000, 32'hFFEC_0000, 32'h0000_0007, Q_ZERO));
      // negative radius passes through
      pending_reqs.push_back(make_item(OP_SET_SPHERE, 16'h8000, 2'd0, 32'h0001_8000,
                                       32'hFFFD_C000, Q_MAX, 32'hFFFD_0000));
      // extreme matrix, saturating sums
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h1234, 2'd0, Q_MAX, Q_MAX, Q_MAX,
                                       Q_ZERO));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h4321, 2'd1, Q_MIN, Q_MIN, Q_MIN,
                                       Q_ZERO));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h5555, 2'd2, Q_MIN, Q_MAX,
                                       32'hFFFF_FFFF, Q_ZERO));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'hAAAA, COL_TRANSLATION, Q_MAX,
                                       Q_MIN, Q_MAX, Q_MAX));
      pending_reqs.push_back(make_item(OP_SET_SPHERE, 16'h7FFF, 2'd1, Q_MAX, Q_MAX, Q_MAX,
                                       Q_MAX));
      pending_reqs.push_back(make_item(OP_SET_SPHERE, 16'h00FF, 2'd2, Q_MIN, Q_MIN, Q_MIN,
                                       Q_MIN));
      pending_reqs.push_back(make_item(OP_SET_SPHERE, 16'hFF00, 2'd3, Q_MIN, Q_MAX, Q_ZERO,
                                       32'hFFFF_FFFF));
      // back to a zero matrix: radius zero whatever the local radius
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h0010, 2'd0, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_MAX));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h0011, 2'd1, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h0012, 2'd2, Q_ZERO, Q_ZERO, Q_ZERO,
                                       Q_ZERO));
      pending_reqs.push_back(make_item(OP_WRITE_COLUMN, 16'h0013, COL_TRANSLATION, Q_ZERO,
                                       Q_ZERO, Q_ZERO, Q_ZERO));
      pending_reqs.push_back(make_item(OP_SET_SPHERE, 16'h0014, 2'd0, Q_ONE, Q_ONE, Q_ONE,
                                       Q_MAX));

      // random part: mostly whole matrix updates and sphere sets, some noise
      while (pending_reqs.size() < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            for (int c = 0; c < 3; c++) push_column(2'(c));
            push_column(COL_TRANSLATION);
         end else if (kind < 7) begin
            push_sphere();
         end else if ($urandom_range(0, 1) == 0) begin
            push_column(2'($urandom));
         end else begin
            pending_reqs.push_back(make_item(1'($urandom), 16'($urandom), 2'($urandom),
                                             $urandom, $urandom, $urandom, $urandom));
         end
      end
      total_items = pending_reqs.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (items_taken < total_items) @(posedge clock);
      while (sphere_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sphere_due.size() > 0) begin
         error_count += sphere_due.size();
         $display("%0d world spheres never arrived", sphere_due.size());
      end
      $display("sent %0d items (%0d column writes, %0d sphere sets) in %0d cycles",
               items_taken, column_writes, sphere_sets, cycle_count);
      $display("checked %0d world spheres, %0d field mismatches", spheres_checked,
               mismatch_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// File: files.f
src/bst_pkg.sv
src/bst_if.sv
src/bst_ctrl.sv
src/bst_dp.sv
src/bounding_sphere_transform_top.sv
bench/tb_bounding_sphere_transform_top.sv
